// ===== src/rcd_pkg.sv =====
// Shared types and constants for the command deframer.
// No dependencies; imported by rcd_step and resp_command_deframer.
`default_nettype none

package rcd_pkg;

  localparam int POS_W   = 12;
  localparam int ARG_W   = 10;
  localparam int LEN_W   = 4;
  localparam int ERR_W   = 3;
  localparam int KIND_W  = 2;

  // Framing characters
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Byte classes
  localparam logic [KIND_W-1:0] KIND_FRAME = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DISC  = 2'd2;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE    = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NO_STAR = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NO_CNT  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NO_CR   = 3'd3;
  localparam logic [ERR_W-1:0] ERR_NO_LF   = 3'd4;
  localparam logic [ERR_W-1:0] ERR_NO_DOL  = 3'd5;
  localparam logic [ERR_W-1:0] ERR_NO_LEN  = 3'd6;
  localparam logic [ERR_W-1:0] ERR_NO_CRLF = 3'd7;

  typedef enum logic [3:0] {
    PH_STAR   = 4'd0,
    PH_NDIG   = 4'd1,
    PH_HCR    = 4'd2,
    PH_HLF    = 4'd3,
    PH_DOLLAR = 4'd4,
    PH_LDIG   = 4'd5,
    PH_LCR    = 4'd6,
    PH_LLF    = 4'd7,
    PH_DATA   = 4'd8,
    PH_PCR    = 4'd9,
    PH_PLF    = 4'd10
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [LEN_W-1:0]   left;
    logic [POS_W-1:0]   pos;
    logic [ARG_W-1:0]   args;
    logic [LEN_W-1:0]   count;
    logic               err;
    logic [ERR_W-1:0]   ekind;
    logic [POS_W-1:0]   eoff;
  } state_t;

  localparam state_t ST_RESET = '{phase: PH_STAR, default: '0};

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [7:0]         payload;
    logic [ARG_W-1:0]   arg_number;
    logic               arg_end;
    logic               done;
    logic               failed;
    logic [ERR_W-1:0]   ecode;
    logic [POS_W-1:0]   epos;
    logic [LEN_W-1:0]   dcount;
    logic [ARG_W-1:0]   args_seen;
  } result_t;

endpackage

`default_nettype wire

// ===== src/resp_command_deframer.sv =====
// Path: a result is offered on m_* after its input transfer passes the input
// register, then the result register; m_tready held low stalls it on the way.
// One byte per cycle while m_tready is high; one result transfer per input transfer.
// Input register, then the parse step, then the result register with parser state.
// Reset (rst, synchronous, active high) empties both stages and returns the
// parser to the start of a command; the next byte is expected to be '*'.
`default_nettype none

module resp_command_deframer #(
  parameter int MAX_CMD_BYTES = 4096,
  parameter int MAX_ARGS      = 1024
) (
  input  wire         clk,
  input  wire         rst,
  // Byte stream in
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] data_byte
  input  wire         s_tlast,   // last_byte
  // Result stream out
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [47:0] m_tdata,   // [7:0] payload, [17:8] arg_number, [18] failed,
                                 // [21:19] error_code, [33:22] error_position,
                                 // [37:34] declared_count, [47:38] args_seen
  output logic [2:0]  m_tuser,   // [1:0] byte_kind, [2] arg_end
  output logic        m_tlast    // done_res
);
  import rcd_pkg::*;

  // Saturation points for the byte offset and argument counter
  localparam int PosTopInt = (MAX_CMD_BYTES - 1 < 4095) ? MAX_CMD_BYTES - 1 : 4095;
  localparam int ArgTopInt = (MAX_ARGS - 1 < 1023) ? MAX_ARGS - 1 : 1023;

  // Input stage
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Parser state and result stage
  state_t     st;
  state_t     st_next;
  result_t    res_next;
  result_t    out_res;
  logic       out_valid;

  logic       adv;   // result stage can take a new entry
  logic       load;  // input stage moves into result stage

  assign adv      = !out_valid || m_tready;
  assign load     = in_valid && adv;
  assign s_tready = !in_valid || adv;

  rcd_step #(
    .POS_TOP (PosTopInt),
    .ARG_TOP (ArgTopInt)
  ) u_step (
    .cur       (st),
    .data_byte (in_byte),
    .last_byte (in_last),
    .nxt       (st_next),
    .res       (res_next)
  );

  // Control: valid bits and parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= ST_RESET;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (adv) out_valid <= in_valid;
      if (load) st <= st_next;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
    if (load) out_res <= res_next;
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_res.done;
  assign m_tuser  = {out_res.arg_end, out_res.kind};
  assign m_tdata  = {out_res.args_seen, out_res.dcount, out_res.epos, out_res.ecode,
                     out_res.failed, out_res.arg_number, out_res.payload};

  // A latched error sticks until the command's final byte goes through
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    st.err && !(load && in_last) |=> st.err)
    else $error("error flag dropped mid-command");

  // The final byte leaves the parser at the start of a new command
  a_clean_restart: assert property (@(posedge clk) disable iff (rst)
    load && in_last |=> st.phase == PH_STAR && st.pos == '0 && !st.err)
    else $error("parser state not cleared after final byte");

  // Discarded bytes only appear once an error is latched
  a_disc_failed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.kind == KIND_DISC |-> out_res.failed)
    else $error("discarded byte without latched error");

  // Error code is nonzero exactly when failed
  a_code_failed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.failed == (out_res.ecode != ERR_NONE)))
    else $error("error code and failed flag disagree");

  // Argument end is marked only on payload bytes
  a_end_on_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.arg_end |-> out_res.kind == KIND_DATA)
    else $error("arg_end on a non-payload byte");

endmodule

`default_nettype wire

// ===== src/rcd_step.sv =====
// Next-state and result logic for one command byte.
// Depends on rcd_pkg.
`default_nettype none

module rcd_step #(
  parameter int POS_TOP = 4095,
  parameter int ARG_TOP = 1023
) (
  input  var rcd_pkg::state_t  cur,
  input  wire [7:0]            data_byte,
  input  wire                  last_byte,
  output rcd_pkg::state_t      nxt,
  output rcd_pkg::result_t     res
);
  import rcd_pkg::*;

  localparam logic [POS_W-1:0] PosTop = POS_W'(POS_TOP);
  localparam logic [ARG_W-1:0] ArgTop = ARG_W'(ARG_TOP);

  always_comb begin
    state_t            n;
    logic [KIND_W-1:0] kind;
    logic [7:0]        pay;
    logic              aend;
    logic [POS_W-1:0]  next_pos;
    logic              lat;
    logic [ERR_W-1:0]  lcode;
    logic [POS_W-1:0]  lpos;
    logic [7:0]        digit;
    logic              is_dig;

    n        = cur;
    kind     = KIND_FRAME;
    pay      = 8'd0;
    aend     = 1'b0;
    next_pos = (cur.pos < PosTop) ? cur.pos + POS_W'(1) : PosTop;
    lat      = 1'b0;
    lcode    = ERR_NONE;
    lpos     = cur.pos;
    digit    = data_byte - CH_ZERO;
    is_dig   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);

    if (cur.err) begin
      kind = KIND_DISC;
    end else begin
      case (cur.phase)
        PH_STAR: begin
          if (data_byte == CH_STAR) n.phase = PH_NDIG;
          else begin lat = 1'b1; lcode = ERR_NO_STAR; end
        end
        PH_NDIG: begin
          if (is_dig) begin
            n.count = digit[LEN_W-1:0];
            n.phase = PH_HCR;
          end else begin
            lat = 1'b1; lcode = ERR_NO_CNT;
          end
        end
        PH_HCR: begin
          if (data_byte == CH_CR) n.phase = PH_HLF;
          else begin lat = 1'b1; lcode = ERR_NO_CR; end
        end
        PH_HLF: begin
          if (data_byte == CH_LF) n.phase = PH_DOLLAR;
          else begin lat = 1'b1; lcode = ERR_NO_LF; end
        end
        PH_DOLLAR: begin
          if (data_byte == CH_DOLLAR) n.phase = PH_LDIG;
          else begin lat = 1'b1; lcode = ERR_NO_DOL; end
        end
        PH_LDIG: begin
          if (is_dig) begin
            n.left  = digit[LEN_W-1:0];
            n.phase = PH_LCR;
          end else begin
            lat = 1'b1; lcode = ERR_NO_LEN;
          end
        end
        PH_LCR: begin
          if (data_byte == CH_CR) n.phase = PH_LLF;
          else begin lat = 1'b1; lcode = ERR_NO_CR; end
        end
        PH_LLF: begin
          if (data_byte == CH_LF) n.phase = (cur.left == '0) ? PH_PCR : PH_DATA;
          else begin lat = 1'b1; lcode = ERR_NO_LF; end
        end
        PH_DATA: begin
          kind = KIND_DATA;
          pay  = data_byte;
          if (cur.left != '0) n.left = cur.left - LEN_W'(1);
          if (n.left == '0) begin
            aend    = 1'b1;
            n.phase = PH_PCR;
          end
        end
        PH_PCR: begin
          if (data_byte == CH_CR) n.phase = PH_PLF;
          else begin lat = 1'b1; lcode = ERR_NO_CR; end
        end
        PH_PLF: begin
          if (data_byte == CH_LF) begin
            n.phase = PH_DOLLAR;
            if (cur.args < ArgTop) n.args = cur.args + ARG_W'(1);
          end else begin
            lat = 1'b1; lcode = ERR_NO_LF;
          end
        end
        default: begin
          lat = 1'b1; lcode = ERR_NO_STAR;
        end
      endcase
    end

    // Command ended before a clean boundary: flag what was due next
    if (last_byte && !cur.err && !lat && n.phase != PH_DOLLAR) begin
      lat  = 1'b1;
      lpos = next_pos;
      case (n.phase)
        PH_NDIG: lcode = ERR_NO_CNT;
        PH_HCR:  lcode = ERR_NO_CR;
        PH_HLF:  lcode = ERR_NO_LF;
        PH_LDIG: lcode = ERR_NO_LEN;
        PH_LCR:  lcode = ERR_NO_CR;
        PH_LLF:  lcode = ERR_NO_LF;
        PH_DATA: lcode = ERR_NO_CRLF;
        PH_PCR:  lcode = ERR_NO_CRLF;
        PH_PLF:  lcode = ERR_NO_LF;
        default: lcode = ERR_NO_STAR;
      endcase
    end

    if (lat) begin
      n.err   = 1'b1;
      n.ekind = lcode;
      n.eoff  = lpos;
    end

    res.kind       = kind;
    res.payload    = pay;
    res.arg_number = n.args;
    res.arg_end    = aend;
    res.done       = last_byte;
    res.failed     = n.err;
    res.ecode      = n.ekind;
    res.epos       = n.eoff;
    res.dcount     = n.count;
    res.args_seen  = n.args;

    if (last_byte) n = ST_RESET;
    else           n.pos = next_pos;

    nxt = n;
  end

endmodule

`default_nettype wire
